// ===== rtl/jet_pkg.sv =====
// jet_pkg: widths, fixed-point formats, register indexes and reset values
// for the julia escape-time block; no dependencies

package jet_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRACTION_BITS = 28;
   localparam int PROD_W        = 2 * DATA_WIDTH;
   localparam int CFG_W         = 30;
   localparam int LIMIT_W       = 16;
   localparam int COUNT_W       = 17;
   localparam int INDEX_W       = 2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic        [CFG_W-1:0]      cfg_type;
   typedef logic        [LIMIT_W-1:0]    limit_type;
   typedef logic        [COUNT_W-1:0]    count_type;
   typedef logic        [INDEX_W-1:0]    index_type;

   // register indexes on the csr port
   localparam index_type REG_C_REAL = INDEX_W'(0);
   localparam index_type REG_C_IMAG = INDEX_W'(1);
   localparam index_type REG_LIMIT  = INDEX_W'(2);

   // reset values: -0.8, 0.156 in Q2.28, limit 255
   localparam cfg_type   C_REAL_RESET = cfg_type'(-214748365);
   localparam cfg_type   C_IMAG_RESET = cfg_type'(41875931);
   localparam limit_type LIMIT_RESET  = limit_type'(255);

   // escape radius squared: 4.0 with twice the fraction bits
   localparam logic [PROD_W-1:0] NORM_LIMIT = PROD_W'(4) << (2 * FRACTION_BITS);

   // sign extend a configuration-width value to the datapath width
   function automatic data_type sext_cfg(input cfg_type v);
      sext_cfg = {{(DATA_WIDTH-CFG_W){v[CFG_W-1]}}, v};
   endfunction

endpackage

// ===== rtl/jet_mul.sv =====
// jet_mul: shared signed multiplier with registered product
// depends on jet_pkg for the datapath and product widths

module jet_mul (
   input  logic              clock,
   input  jet_pkg::data_type mul_a,
   input  jet_pkg::data_type mul_b,
   output jet_pkg::prod_type product
);

   jet_pkg::prod_type product_ff;
   jet_pkg::prod_type product_in;

   assign product_in = jet_pkg::prod_type'(mul_a) * jet_pkg::prod_type'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== rtl/julia_escape_time.sv =====
// julia_escape_time: top level, sequencer, configuration registers and result register
// depends on jet_pkg and jet_mul
//
// usage
//  - req channel: one starting point (start_real, start_imag, signed Q2.28) per
//    transaction; req_ready is high only while the sequencer is idle
//  - rsp channel: one iteration_count per transaction: 0 if the point starts
//    outside radius 2, k if it escapes after k steps, limit+1 if the limit ends it
//  - csr port: c_real, c_imag, iteration_limit written with csr_we; write only
//    while idle, unknown indexes are ignored
//  - each pass through the loop runs on the one shared multiplier through the
//    states x*x, y*y, x*y and update; the result of a point goes to the output
//    register from the hold state, and the block takes the next point only
//    after it has returned to idle, so points are not overlapped
//  - the result sits in an output register, so the next point can be accepted
//    while the previous result waits; if the receiver stalls and the next point
//    finishes too, the sequencer holds until the output register frees
//  - reset (synchronous, active high) returns to idle, drops any pending result
//    and restores the constant -0.8 + 0.156i and a limit of 255

module julia_escape_time (
   input  logic                clock,
   input  logic                reset,
   // input points
   input  logic                req_valid,
   output logic                req_ready,
   input  jet_pkg::cfg_type    req_start_real,
   input  jet_pkg::cfg_type    req_start_imag,
   // results
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output jet_pkg::count_type  rsp_iteration_count,
   // configuration
   input  logic                csr_we,
   input  jet_pkg::index_type  csr_index,
   input  jet_pkg::cfg_type    csr_wdata
);

   localparam int LO_RE = jet_pkg::FRACTION_BITS;
   localparam int HI_RE = jet_pkg::FRACTION_BITS + jet_pkg::DATA_WIDTH - 1;
   localparam int LO_IM = jet_pkg::FRACTION_BITS - 1;
   localparam int HI_IM = jet_pkg::FRACTION_BITS + jet_pkg::DATA_WIDTH - 2;

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_XX   = 3'd1;   // multiply x*x
   localparam logic [2:0] ST_YY   = 3'd2;   // multiply y*y, capture x*x
   localparam logic [2:0] ST_XY   = 3'd3;   // multiply x*y, test norm
   localparam logic [2:0] ST_UPD  = 3'd4;   // form the new point
   localparam logic [2:0] ST_HOLD = 3'd5;   // wait for the output register

   logic [2:0]           state_ff,     state_in;
   jet_pkg::cfg_type     c_real_ff,    c_real_in;
   jet_pkg::cfg_type     c_imag_ff,    c_imag_in;
   jet_pkg::limit_type   limit_ff,     limit_in;
   jet_pkg::data_type    x_ff,         x_in;
   jet_pkg::data_type    y_ff,         y_in;
   jet_pkg::prod_type    xx_ff,        xx_in;
   jet_pkg::prod_type    diff_ff,      diff_in;
   jet_pkg::count_type   count_ff,     count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   jet_pkg::count_type   rsp_count_ff, rsp_count_in;

   jet_pkg::data_type    mul_a;
   jet_pkg::data_type    mul_b;
   jet_pkg::prod_type    product;
   logic [jet_pkg::PROD_W-1:0] norm;
   logic                 out_free;

   jet_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // operand selection for the shared multiplier
   always_comb begin
      case (state_ff)
         ST_XX: begin
            mul_a = x_ff;
            mul_b = x_ff;
         end
         ST_YY: begin
            mul_a = y_ff;
            mul_b = y_ff;
         end
         default: begin
            mul_a = x_ff;
            mul_b = y_ff;
         end
      endcase
   end

   // squared norm from x*x (held) and y*y (fresh product); both are non-negative
   assign norm     = jet_pkg::PROD_W'(xx_ff) + jet_pkg::PROD_W'(product);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      limit_in     = limit_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      xx_in        = xx_ff;
      diff_in      = diff_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            jet_pkg::REG_C_REAL: c_real_in = csr_wdata;
            jet_pkg::REG_C_IMAG: c_imag_in = csr_wdata;
            jet_pkg::REG_LIMIT:  limit_in  = csr_wdata[jet_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end

      // result taken by the receiver
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = jet_pkg::sext_cfg(req_start_real);
               y_in     = jet_pkg::sext_cfg(req_start_imag);
               count_in = '0;
               state_in = ST_XX;
            end
         end
         ST_XX: begin
            state_in = ST_YY;
         end
         ST_YY: begin
            xx_in    = product;
            state_in = ST_XY;
         end
         ST_XY: begin
            diff_in = xx_ff - product;
            if (norm > jet_pkg::NORM_LIMIT) begin
               // escaped: count stands as it is
               state_in = ST_HOLD;
            end else begin
               count_in = count_ff + jet_pkg::COUNT_W'(1);
               if (count_ff < jet_pkg::COUNT_W'(limit_ff)) begin
                  state_in = ST_UPD;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_UPD: begin
            // floor shift then wrap to the datapath width, plus the constant
            x_in     = diff_ff[HI_RE:LO_RE] + jet_pkg::sext_cfg(c_real_ff);
            y_in     = product[HI_IM:LO_IM] + jet_pkg::sext_cfg(c_imag_ff);
            state_in = ST_XX;
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         c_real_ff    <= jet_pkg::C_REAL_RESET;
         c_imag_ff    <= jet_pkg::C_IMAG_RESET;
         limit_ff     <= jet_pkg::LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         c_real_ff    <= c_real_in;
         c_imag_ff    <= c_imag_in;
         limit_ff     <= limit_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      xx_ff        <= xx_in;
      diff_ff      <= diff_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

endmodule

// ===== sim/julia_escape_time_test.sv =====
// julia_escape_time_test: self-checking testbench for the julia escape-time block
// holds an escape-count scoreboard class and the stimulus tasks
// depends on jet_pkg and julia_escape_time

class escape_scoreboard;
   jet_pkg::cfg_type   c_real;
   jet_pkg::cfg_type   c_imag;
   jet_pkg::limit_type iter_limit;
   jet_pkg::count_type predicted_counts[$];
   int unsigned        failures;

   function new();
      c_real     = 30'd858993459;   // -0.8
      c_imag     = 30'd41875931;    // 0.156
      iter_limit = 16'd255;
      failures   = 0;
   endfunction

   function void write_reg(jet_pkg::index_type idx, jet_pkg::cfg_type val);
      case (idx)
         jet_pkg::REG_C_REAL: c_real = val;
         jet_pkg::REG_C_IMAG: c_imag = val;
         jet_pkg::REG_LIMIT:  iter_limit = val[jet_pkg::LIMIT_W-1:0];
         default: ;
      endcase
   endfunction

   // escape count of one starting point under the current constant and limit
   function jet_pkg::count_type escape_count(jet_pkg::cfg_type re, jet_pkg::cfg_type im);
      longint signed     x, y, cr, ci, sq_diff, xy_prod, wide;
      longint unsigned   mx, my, norm, escape_norm;
      jet_pkg::data_type nx, ny;
      int unsigned       steps;
      bit                done;
      x           = longint'($signed(re));
      y           = longint'($signed(im));
      cr          = longint'($signed(c_real));
      ci          = longint'($signed(c_imag));
      escape_norm = 64'd4 << (2 * jet_pkg::FRACTION_BITS);
      steps       = 0;
      done        = 1'b0;
      while (!done) begin
         mx   = (x < 0) ? -x : x;
         my   = (y < 0) ? -y : y;
         norm = mx * mx + my * my;
         if (norm > escape_norm) begin
            done = 1'b1;
         end else if (steps >= iter_limit) begin
            steps++;
            done = 1'b1;
         end else begin
            steps++;
            sq_diff = x * x - y * y;
            xy_prod = x * y;
            // floor shift then add c, wrapping to the datapath width
            wide = (sq_diff >>> jet_pkg::FRACTION_BITS) + cr;
            nx   = wide[jet_pkg::DATA_WIDTH-1:0];
            wide = (xy_prod >>> (jet_pkg::FRACTION_BITS - 1)) + ci;
            ny   = wide[jet_pkg::DATA_WIDTH-1:0];
            x    = longint'(nx);
            y    = longint'(ny);
         end
      end
      escape_count = steps[jet_pkg::COUNT_W-1:0];
   endfunction

   function void fail_note(string msg);
      failures++;
      if (failures <= 10) begin
         $display("%s", msg);
      end
   endfunction

   function void note_point(jet_pkg::cfg_type re, jet_pkg::cfg_type im);
      predicted_counts.push_back(escape_count(re, im));
   endfunction

   function void check_count(jet_pkg::count_type seen);
      jet_pkg::count_type want;
      if (predicted_counts.size() == 0) begin
         fail_note($sformatf("unexpected result: iteration_count %0d", seen));
      end else begin
         want = predicted_counts.pop_front();
         if (seen !== want) begin
            fail_note($sformatf("iteration_count mismatch: expected %0d, got %0d",
                                want, seen));
         end
      end
   endfunction
endclass

module julia_escape_time_test;

   localparam int                 CYCLE_LIMIT   = 10_000_000;
   localparam int                 RANDOM_PHASES = 12;
   localparam int                 PHASE_POINTS  = 125;
   localparam jet_pkg::index_type REG_SPARE     = 2'd3;           // no register behind it
   localparam jet_pkg::cfg_type   Q_MIN         = 30'h2000_0000;  // -2.0
   localparam jet_pkg::cfg_type   Q_MAX         = 30'h1fff_ffff;  // just below 2.0
   localparam jet_pkg::cfg_type   Q_ONE         = 30'h1000_0000;  // 1.0
   localparam jet_pkg::cfg_type   Q_DIAG_IN     = 30'd379625062;  // |z| just inside, diagonal
   localparam jet_pkg::cfg_type   Q_DIAG_OUT    = 30'd379625063;  // and just outside

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   jet_pkg::cfg_type    req_start_real;
   jet_pkg::cfg_type    req_start_imag;
   logic                rsp_valid;
   logic                rsp_ready;
   jet_pkg::count_type  rsp_iteration_count;
   logic                csr_we;
   jet_pkg::index_type  csr_index;
   jet_pkg::cfg_type    csr_wdata;

   escape_scoreboard   escapes;
   bit                 calm;      // phases with no idling on either side

   julia_escape_time dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_start_real      (req_start_real),
      .req_start_imag      (req_start_imag),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #5 clock = ~clock;

   // idle length: mostly none or short, now and then a long one
   function int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55) begin
         pick_gap = 0;
      end else if (roll < 90) begin
         pick_gap = $urandom_range(1, 3);
      end else if (roll < 98) begin
         pick_gap = $urandom_range(4, 20);
      end else begin
         pick_gap = $urandom_range(30, 150);
      end
   endfunction

   // low bits of a signed integer as a q2.28 field
   function jet_pkg::cfg_type q_value(int signed v);
      q_value = v[jet_pkg::CFG_W-1:0];
   endfunction

   // random coordinate: full range, close to the origin, or hugging radius 2
   function jet_pkg::cfg_type random_coord();
      int unsigned pick;
      int signed   offs;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         random_coord = q_value($urandom);
      end else if (pick < 85) begin
         offs         = $urandom_range(0, 1 << 28);
         random_coord = q_value(offs - (1 << 27));
      end else begin
         offs         = $urandom_range(0, 4095);
         random_coord = pick[0] ? q_value(offs - (1 << 29)) : q_value((1 << 29) - 1 - offs);
      end
   endfunction

   // one point transaction; valid stays up across back-to-back points
   task send_point(jet_pkg::cfg_type re, jet_pkg::cfg_type im);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_real <= re;
      req_start_imag <= im;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      escapes.note_point(re, im);
   endtask

   // stop sending and wait for every outstanding count
   task drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (escapes.predicted_counts.size() != 0);
   endtask

   task write_reg(jet_pkg::index_type idx, jet_pkg::cfg_type val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      escapes.write_reg(idx, val);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // new constant and limit, only once the block has gone idle
   task set_phase(jet_pkg::cfg_type cr, jet_pkg::cfg_type ci, jet_pkg::limit_type lim);
      drain();
      write_reg(jet_pkg::REG_C_REAL, cr);
      write_reg(jet_pkg::REG_C_IMAG, ci);
      write_reg(jet_pkg::REG_LIMIT, {{(jet_pkg::CFG_W-jet_pkg::LIMIT_W){1'b0}}, lim});
   endtask

   // result side: check every accepted transaction, stall at random
   initial begin
      int unsigned hold;
      rsp_ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            escapes.check_count(rsp_iteration_count);
         end
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else begin
            rsp_ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // watchdog
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("julia_escape_time_test NOT OK");
      $finish;
   end

   initial begin
      jet_pkg::cfg_type   cr, ci;
      jet_pkg::limit_type lim;
      escapes = new();
      calm    = 1'b0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_start_real <= '0;
      req_start_imag <= '0;
      csr_we         <= 1'b0;
      csr_index      <= jet_pkg::REG_C_REAL;
      csr_wdata      <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset constant -0.8 + 0.156i and limit 255, nothing written yet
      send_point(30'd0, 30'd0);
      send_point(Q_MIN, Q_MIN);          // far corner, outside at once
      send_point(Q_MAX, Q_MAX);
      send_point(Q_MIN, 30'd0);          // norm exactly 4 counts as inside
      send_point(30'd0, Q_MIN);
      send_point(Q_MAX, 30'd0);          // just inside on the axis
      send_point(Q_MIN, 30'd1);          // one lsb beyond radius 2
      send_point(Q_DIAG_IN, Q_DIAG_IN);
      send_point(q_value(-379625063), Q_DIAG_OUT);

      // a write to the spare index must leave every register alone
      drain();
      write_reg(REG_SPARE, 30'h3fff_ffff);
      send_point(30'd0, 30'd0);

      // limit zero: inside gives 1, outside gives 0, no step taken
      drain();
      write_reg(jet_pkg::REG_LIMIT, 30'd0);
      send_point(30'd0, 30'd0);
      send_point(Q_MIN, 30'd1);
      send_point(Q_MIN, 30'd0);

      // extreme constants with the smallest useful limit
      set_phase(Q_MIN, Q_MAX, 16'd1);
      send_point(30'd0, 30'd0);
      send_point(Q_ONE, q_value(-(1 << 28)));
      set_phase(Q_MAX, Q_MIN, 16'd1);
      send_point(30'd0, 30'd0);

      // c = 0 with the largest limit: the origin never moves and hits limit + 1
      set_phase(30'd0, 30'd0, 16'hffff);
      send_point(30'd0, 30'd0);
      send_point(q_value(3 << 27), 30'd0);

      // random phases, each with its own constant and limit
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         calm = (p % 4 == 1);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               // well-known julia constants, where points tend to linger
               case ($urandom_range(0, 4))
                  0: begin cr = q_value(-214748365); ci = q_value(41875931);   end
                  1: begin cr = q_value(76504105);   ci = q_value(2684355);    end
                  2: begin cr = q_value(-107374182); ci = q_value(161061274);  end
                  3: begin cr = q_value(-188377266); ci = q_value(-103132902); end
                  default: begin cr = q_value(-201326592); ci = q_value(29527900); end
               endcase
            end
            4, 5, 6, 7: begin
               cr = q_value($urandom);
               ci = q_value($urandom);
            end
            default: begin
               cr = ($urandom_range(0, 1) != 0) ? Q_MIN : Q_MAX;
               ci = ($urandom_range(0, 2) == 0) ? 30'd0 :
                    (($urandom_range(0, 1) != 0) ? Q_MIN : Q_MAX);
            end
         endcase
         if (p == 0) begin
            lim = 16'd255;
         end else if (p == RANDOM_PHASES - 1) begin
            lim = 16'd1;
         end else if ($urandom_range(0, 99) < 80) begin
            lim = jet_pkg::limit_type'($urandom_range(1, 40));
         end else begin
            lim = jet_pkg::limit_type'($urandom_range(41, 100));
         end
         set_phase(cr, ci, lim);
         repeat (PHASE_POINTS) send_point(random_coord(), random_coord());
      end

      // wait for the last counts, then a short quiet window for strays
      calm = 1'b0;
      drain();
      repeat (64) @(posedge clock);
      if (escapes.failures == 0) begin
         $display("julia_escape_time_test OK");
      end else begin
         $display("julia_escape_time_test NOT OK");
      end
      $finish;
   end

endmodule
